// ----- rtl/json_string_unescape_utf8_macros.svh -----
// assertion macros used by the checker file
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication, off during reset
`define JSU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu check failed");

// next-cycle implication, off during reset
`define JSU_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu check failed");

// next-cycle implication, also checked across reset
`define JSU_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("jsu check failed");

`endif

// ----- rtl/jsu_pkg.sv -----
// shared types, codes and constants of the json string unescaper
`default_nettype none
package jsu_pkg;

   // decoder modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;

   // end status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ESCAPE = 3'd1;
   localparam logic [2:0] ST_BAD_HEX    = 3'd2;
   localparam logic [2:0] ST_TRUNCATED  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW   = 3'd4;

   // input op codes
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // special characters
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_U         = 8'h75;

   // capacity register
   localparam int         CAP_W     = 13;
   localparam logic [12:0] CAP_MAX   = 13'd4096;
   localparam logic [12:0] CAP_RESET = 13'd256;

   // queue between decoder and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one queued word: a 1 to 3 byte group or an end status
   typedef struct packed {
      logic        is_end;
      logic [1:0]  count;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [2:0]  status;
      logic [11:0] length;
   } queue_entry_type;

   // escape letter decode: {known, byte}
   function automatic logic [8:0] esc_decode(input logic [7:0] c);
      logic [8:0] r;
      r = '0;
      unique case (c)
         8'h22:   r = {1'b1, 8'h22};
         8'h5c:   r = {1'b1, 8'h5c};
         8'h2f:   r = {1'b1, 8'h2f};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0c};
         8'h6e:   r = {1'b1, 8'h0a};
         8'h72:   r = {1'b1, 8'h0d};
         8'h74:   r = {1'b1, 8'h09};
         default: r = '0;
      endcase
      return r;
   endfunction

   // hex digit decode: {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/jsu_front.sv -----
// front end: escape decoding, utf-8 grouping, capacity check
`default_nettype none
module jsu_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_op,
   input  wire logic [7:0]                req_ch,
   input  wire logic                      csr_valid,
   input  wire logic [12:0]               csr_capacity,
   input  wire logic                      full,
   output logic                           push,
   output jsu_pkg::queue_entry_type       entry
);

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [15:0] accum_ff, accum_in;
   logic [11:0] written_ff, written_in;
   logic [2:0]  err_ff, err_in;
   logic [12:0] cap_ff;
   logic [12:0] cap_eff;
   logic        accept;
   logic [8:0]  esc;
   logic [4:0]  nib;
   logic [15:0] cp;

   assign accept  = req_valid && !full;
   assign cap_eff = (cap_ff > jsu_pkg::CAP_MAX) ? jsu_pkg::CAP_MAX : cap_ff;
   assign esc     = jsu_pkg::esc_decode(req_ch);
   assign nib     = jsu_pkg::hex_decode(req_ch);
   assign cp      = {accum_ff[11:0], nib[3:0]};

   // decode one character or an end op, build the byte group and check it against capacity
   always_comb begin
      logic       grp_go;
      logic [1:0] grp_n;
      logic [7:0] g0, g1, g2;
      logic [2:0] st;
      grp_go     = 1'b0;
      grp_n      = 2'd1;
      g0         = '0;
      g1         = '0;
      g2         = '0;
      st         = err_ff;
      mode_in    = mode_ff;
      hex_cnt_in = hex_cnt_ff;
      accum_in   = accum_ff;
      written_in = written_ff;
      err_in     = err_ff;
      push       = 1'b0;
      entry      = '0;
      if (accept) begin
         if (req_op == jsu_pkg::OP_END) begin
            if (st == jsu_pkg::ST_OK && mode_ff != jsu_pkg::MODE_NORMAL) begin
               st = jsu_pkg::ST_TRUNCATED;
            end
            if (st == jsu_pkg::ST_OK && ({1'b0, written_ff} + 13'd1) > cap_eff) begin
               st = jsu_pkg::ST_OVERFLOW;
            end
            push         = 1'b1;
            entry.is_end = 1'b1;
            entry.status = st;
            entry.length = written_ff;
            mode_in      = jsu_pkg::MODE_NORMAL;
            hex_cnt_in   = '0;
            accum_in     = '0;
            written_in   = '0;
            err_in       = jsu_pkg::ST_OK;
         end else if (err_ff == jsu_pkg::ST_OK) begin
            unique case (mode_ff)
               jsu_pkg::MODE_NORMAL: begin
                  if (req_ch == jsu_pkg::CH_BACKSLASH) begin
                     mode_in = jsu_pkg::MODE_ESCAPE;
                  end else begin
                     grp_go = 1'b1;
                     g0     = req_ch;
                  end
               end
               jsu_pkg::MODE_ESCAPE: begin
                  mode_in = jsu_pkg::MODE_NORMAL;
                  if (req_ch == jsu_pkg::CH_U) begin
                     mode_in    = jsu_pkg::MODE_HEX;
                     hex_cnt_in = '0;
                     accum_in   = '0;
                  end else if (esc[8]) begin
                     grp_go = 1'b1;
                     g0     = esc[7:0];
                  end else begin
                     err_in = jsu_pkg::ST_BAD_ESCAPE;
                  end
               end
               jsu_pkg::MODE_HEX: begin
                  if (!nib[4]) begin
                     err_in  = jsu_pkg::ST_BAD_HEX;
                     mode_in = jsu_pkg::MODE_NORMAL;
                  end else if (hex_cnt_ff != 2'd3) begin
                     accum_in   = cp;
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end else begin
                     mode_in    = jsu_pkg::MODE_NORMAL;
                     hex_cnt_in = '0;
                     accum_in   = '0;
                     grp_go     = 1'b1;
                     // utf-8 encoding of the code point
                     if (cp <= 16'h007f) begin
                        grp_n = 2'd1;
                        g0    = cp[7:0];
                     end else if (cp <= 16'h07ff) begin
                        grp_n = 2'd2;
                        g0    = 8'hc0 | {3'b000, cp[10:6]};
                        g1    = 8'h80 | {2'b00, cp[5:0]};
                     end else begin
                        grp_n = 2'd3;
                        g0    = 8'he0 | {4'b0000, cp[15:12]};
                        g1    = 8'h80 | {2'b00, cp[11:6]};
                        g2    = 8'h80 | {2'b00, cp[5:0]};
                     end
                  end
               end
               default: begin
                  mode_in = jsu_pkg::MODE_NORMAL;
               end
            endcase
            // capacity check for the whole group
            if (grp_go) begin
               if (({1'b0, written_ff} + {11'd0, grp_n}) >= cap_eff) begin
                  err_in = jsu_pkg::ST_OVERFLOW;
               end else begin
                  push        = 1'b1;
                  entry.count = grp_n;
                  entry.b0    = g0;
                  entry.b1    = g1;
                  entry.b2    = g2;
                  written_in  = written_ff + {10'd0, grp_n};
               end
            end
         end
      end
   end

   // decoder state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= jsu_pkg::MODE_NORMAL;
         hex_cnt_ff <= '0;
         accum_ff   <= '0;
         written_ff <= '0;
         err_ff     <= jsu_pkg::ST_OK;
         cap_ff     <= jsu_pkg::CAP_RESET;
      end else begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
         accum_ff   <= accum_in;
         written_ff <= written_in;
         err_ff     <= err_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/jsu_fifo.sv -----
// short queue of decoded words between front and back
`default_nettype none
module jsu_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire jsu_pkg::queue_entry_type  push_entry,
   input  wire logic                      pop,
   output logic                           full,
   output logic                           head_valid,
   output jsu_pkg::queue_entry_type       head
);

   jsu_pkg::queue_entry_type            mem_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QPTR_W-1:0]          wr_ptr_ff;
   logic [jsu_pkg::QPTR_W-1:0]          rd_ptr_ff;
   logic [jsu_pkg::QPTR_W:0]            count_ff, count_in;

   assign full       = (count_ff == (jsu_pkg::QPTR_W+1)'(jsu_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/jsu_back.sv -----
// back end: walks each queued word out one result at a time
`default_nettype none
module jsu_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire jsu_pkg::queue_entry_type  head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_kind,
   output logic [7:0]                     rsp_out_byte,
   output logic [2:0]                     rsp_status,
   output logic [11:0]                    rsp_length,
   output logic                           rsp_last
);

   logic        valid_ff;
   logic [1:0]  idx_ff;
   logic        kind_ff;
   logic [7:0]  byte_ff;
   logic [2:0]  status_ff;
   logic [11:0] length_ff;
   logic        last_ff;
   logic        load;
   logic        cur_last;
   logic [7:0]  cur_byte;

   assign load     = head_valid && (!valid_ff || !rsp_stall);
   assign cur_last = head.is_end || (idx_ff == (head.count - 2'd1));
   assign pop      = load && cur_last;

   // byte of the group at the current position
   always_comb begin
      unique case (idx_ff)
         2'd0:    cur_byte = head.b0;
         2'd1:    cur_byte = head.b1;
         default: cur_byte = head.b2;
      endcase
   end

   // output word valid and group position
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= cur_last ? 2'd0 : idx_ff + 2'd1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // output word payload
   always_ff @(posedge clock) begin
      if (load) begin
         if (head.is_end) begin
            kind_ff   <= jsu_pkg::KIND_END;
            byte_ff   <= '0;
            status_ff <= head.status;
            length_ff <= head.length;
         end else begin
            kind_ff   <= jsu_pkg::KIND_DATA;
            byte_ff   <= cur_byte;
            status_ff <= jsu_pkg::ST_OK;
            length_ff <= '0;
         end
         last_ff <= cur_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_length   = length_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

// ----- rtl/json_string_unescape_utf8.sv -----
// top level of the json string unescaper with utf-8 output
//
//   channel  direction  handshake          word
//   req_     in         valid / stall      op, ch
//   rsp_     out        valid / stall      kind, out_byte, status, length, last
//   csr_     in         valid / ready      capacity (13 bits)
//
// one input word per cycle unless req_stall; a \u escape yields up to 3 output words,
// one per cycle unless rsp_stall. a taken word is queued, then registered at the output.
// the back end emits one result per cycle unless stalled, so a run of multi-byte groups
// is paced by the output register, with a 4-deep queue absorbing the difference.
// req_stall rises only when that queue is full; rsp_stall holds the output register.
// reset is synchronous; all decoder state clears and capacity returns to 256.
`default_nettype none
module json_string_unescape_utf8 (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_op,
   input  wire logic [7:0]   req_ch,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_kind,
   output logic [7:0]        rsp_out_byte,
   output logic [2:0]        rsp_status,
   output logic [11:0]       rsp_length,
   output logic              rsp_last,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [12:0]  csr_capacity
);

   logic                     push;
   logic                     pop;
   logic                     full;
   logic                     head_valid;
   jsu_pkg::queue_entry_type entry;
   jsu_pkg::queue_entry_type head;

   assign req_stall = full;
   assign csr_ready = 1'b1;

   // decoder
   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_op       (req_op),
      .req_ch       (req_ch),
      .csr_valid    (csr_valid),
      .csr_capacity (csr_capacity),
      .full         (full),
      .push         (push),
      .entry        (entry)
   );

   // queue
   jsu_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   // emitter
   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

// ----- rtl/jsu_checker.sv -----
// port-level checks for the json string unescaper, bound to the top level
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"
module jsu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_last
);

   // no result word right after reset
   `JSU_ASSERT_NXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // a stalled word stays offered
   `JSU_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // an end word closes its item and carries a defined status
   `JSU_ASSERT_IMP(a_end_word, clock, reset, rsp_valid && rsp_kind,
      rsp_last && (rsp_status <= jsu_pkg::ST_OVERFLOW))

   // the rest of a utf-8 group follows in the very next cycle
   `JSU_ASSERT_NXT(a_group_cont, clock, reset, rsp_valid && !rsp_stall && !rsp_last,
      rsp_valid && !rsp_kind)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
`default_nettype wire
